// File: hdl/trbp_pkg.sv
// Shared types and constants for the transfer ring TRB producer.
package trbp_pkg;

  localparam int unsigned NUM_RINGS_DEF    = 32;
  localparam int unsigned RING_ENTRIES_DEF = 64;

  // Request opcodes
  localparam logic [1:0] OP_CONTROL = 2'd0;
  localparam logic [1:0] OP_NORMAL  = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;

  // Control word pieces: TRB type sits in bits 15:10
  localparam logic [31:0] CTL_NORMAL = 32'd1 << 10;
  localparam logic [31:0] CTL_SETUP  = 32'd2 << 10;
  localparam logic [31:0] CTL_DATA   = 32'd3 << 10;
  localparam logic [31:0] CTL_STATUS = 32'd4 << 10;
  localparam logic [31:0] CTL_LINK   = 32'd6 << 10;
  localparam logic [31:0] BIT_IDT    = 32'd1 << 6;
  localparam logic [31:0] BIT_IOC    = 32'd1 << 5;
  localparam logic [31:0] BIT_TC     = 32'd1 << 1;
  localparam logic [31:0] BIT_DIR    = 32'd1 << 16;
  localparam logic [31:0] TRT_IN     = 32'd3 << 16;
  localparam logic [31:0] TRT_OUT    = 32'd2 << 16;
  localparam logic [31:0] SETUP_LEN  = 32'd8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    STG_SETUP,
    STG_DATA,
    STG_STATUS,
    STG_NORMAL,
    STG_LINK
  } stage_e;

  typedef struct packed {
    logic capture;
    logic clear;
    logic lookup;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic act;
    logic last;
  } sts_t;

endpackage

// File: hdl/trbp_ctrl.sv
// Sequencer for clearing, ring lookup and TRB emission.
module trbp_ctrl import trbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = sts_i.act ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_CLEAR:  cmd_o.clear = 1'b1;
      ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_EMIT:   cmd_o.emit = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

// File: hdl/trbp_dpath.sv
// Ring state memory, request registers and TRB formation.
module trbp_dpath import trbp_pkg::*; #(
  parameter int unsigned NUM_RINGS    = NUM_RINGS_DEF,
  parameter int unsigned RING_ENTRIES = RING_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  ring_select_i,
  input  logic [63:0] setup_packet_i,
  input  logic [63:0] buffer_address_i,
  input  logic [16:0] buffer_length_i,
  input  logic [63:0] ring_base_i,
  output logic        result_valid_o,
  output logic [4:0]  out_ring_o,
  output logic [5:0]  trb_slot_o,
  output logic [63:0] trb_pointer_o,
  output logic [31:0] trb_status_o,
  output logic [31:0] trb_control_o,
  output logic        last_of_item_o
);

  localparam int unsigned RW = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int unsigned IW = $clog2(RING_ENTRIES);
  localparam int unsigned EW = IW + 2;
  localparam logic [IW-1:0] LAST_SLOT = IW'(RING_ENTRIES - 1);
  localparam logic [RW-1:0] CLR_LAST  = RW'(NUM_RINGS - 1);

  // Entry layout: {ready, cycle, index}
  logic [EW-1:0] mem [NUM_RINGS];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [RW-1:0] wa;
  logic [EW-1:0] wd;

  logic [RW-1:0] clr_q;
  logic [RW-1:0] addr_q;
  logic [1:0]    op_q;
  logic [4:0]    ring_q;
  logic [63:0]   setup_q, buf_q, base_q;
  logic [16:0]   len_q;

  logic [IW-1:0] idx_q, idx_d;
  logic          cyc_q, cyc_d;
  stage_e        stg_q, stg_d, res_q, res_d, follow;
  logic          done_q, done_d;

  logic          in_range, is_in, has_data, is_final, wrap, last;
  logic [IW-1:0] idx_inc;
  logic [63:0]   ptr;
  logic [31:0]   stat, ctl;

  logic          vld_q, last_q;
  logic [5:0]    slot_q;
  logic [63:0]   ptr_q;
  logic [31:0]   stat_q, ctl_q;

  assign in_range = 32'(ring_q) < 32'(NUM_RINGS);
  assign is_in    = setup_q[7];
  assign has_data = (buf_q != 64'd0) && (len_q != 17'd0);
  assign idx_inc  = idx_q + 1'b1;
  assign is_final = (stg_q == STG_STATUS) || (stg_q == STG_NORMAL);
  assign wrap     = (stg_q != STG_LINK) && (idx_inc == LAST_SLOT);
  assign last     = (stg_q == STG_LINK) ? done_q : (is_final && !wrap);

  assign sts_o.clear_done = (clr_q == CLR_LAST);
  assign sts_o.act  = in_range && rd_q[EW-1] && ((op_q == OP_CONTROL) || (op_q == OP_NORMAL));
  assign sts_o.last = last;

  // TRB contents for the current stage
  always_comb begin
    ptr    = 64'd0;
    stat   = 32'd0;
    ctl    = 32'd0;
    follow = stg_q;
    case (stg_q)
      STG_SETUP: begin
        ptr    = setup_q;
        stat   = SETUP_LEN;
        ctl    = CTL_SETUP | BIT_IDT | (has_data ? (is_in ? TRT_IN : TRT_OUT) : 32'd0);
        follow = has_data ? STG_DATA : STG_STATUS;
      end
      STG_DATA: begin
        ptr    = buf_q;
        stat   = 32'(len_q);
        ctl    = CTL_DATA | (is_in ? BIT_DIR : 32'd0);
        follow = STG_STATUS;
      end
      STG_STATUS: begin
        ctl = CTL_STATUS | BIT_IOC | ((has_data && is_in) ? 32'd0 : BIT_DIR);
      end
      STG_NORMAL: begin
        ptr  = buf_q;
        stat = 32'(len_q);
        ctl  = CTL_NORMAL | BIT_IOC;
      end
      STG_LINK: begin
        ptr = base_q;
        ctl = CTL_LINK | BIT_TC;
      end
      default: ctl = 32'd0;
    endcase
    ctl = ctl | 32'(cyc_q);
  end

  // Advance index, cycle bit and stage after each TRB
  always_comb begin
    idx_d  = idx_inc;
    cyc_d  = cyc_q;
    stg_d  = follow;
    res_d  = res_q;
    done_d = done_q;
    if (stg_q == STG_LINK) begin
      idx_d = '0;
      cyc_d = ~cyc_q;
      stg_d = res_q;
    end else if (wrap) begin
      stg_d  = STG_LINK;
      res_d  = follow;
      done_d = is_final;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = addr_q;
    wd = {1'b1, cyc_d, idx_d};
    if (cmd_i.clear) begin
      we = 1'b1;
      wa = clr_q;
      wd = {1'b0, 1'b1, {IW{1'b0}}};
    end else if (cmd_i.lookup && in_range && (op_q == OP_INIT)) begin
      we = 1'b1;
      wd = {1'b1, 1'b1, {IW{1'b0}}};
    end else if (cmd_i.emit && last) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (cmd_i.capture) rd_q <= mem[RW'(ring_select_i)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear && !sts_o.clear_done) clr_q <= clr_q + 1'b1;
      vld_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      ring_q  <= ring_select_i;
      addr_q  <= RW'(ring_select_i);
      setup_q <= setup_packet_i;
      buf_q   <= buffer_address_i;
      len_q   <= buffer_length_i;
      base_q  <= ring_base_i;
    end
    if (cmd_i.lookup) begin
      idx_q  <= rd_q[IW-1:0];
      cyc_q  <= rd_q[IW];
      stg_q  <= (op_q == OP_CONTROL) ? STG_SETUP : STG_NORMAL;
      res_q  <= STG_STATUS;
      done_q <= 1'b0;
    end else if (cmd_i.emit) begin
      idx_q  <= idx_d;
      cyc_q  <= cyc_d;
      stg_q  <= stg_d;
      res_q  <= res_d;
      done_q <= done_d;
    end
    if (cmd_i.emit) begin
      slot_q <= 6'(idx_q);
      ptr_q  <= ptr;
      stat_q <= stat;
      ctl_q  <= ctl;
      last_q <= last;
    end
  end

  assign result_valid_o = vld_q;
  assign out_ring_o     = ring_q;
  assign trb_slot_o     = slot_q;
  assign trb_pointer_o  = ptr_q;
  assign trb_status_o   = stat_q;
  assign trb_control_o  = ctl_q;
  assign last_of_item_o = last_q;

endmodule

// File: hdl/transfer_ring_trb_producer.sv
// Transfer ring TRB producer: top level.
//
// After reset the block clears its ring state memory, one ring per cycle, so busy
// stays high until all NUM_RINGS rings are cleared. A request is
// taken when start is high and busy is low. Every request then goes through a state
// lookup in the ring memory and a decode, then writes its TRBs, one per cycle: none
// for init and dropped requests, one for a normal transfer or two when it wraps the
// ring, and two to four for a control transfer depending on the data stage and a ring
// wrap. Each TRB appears for one cycle with result_valid_o high;
// the receiver must take it then, since the block cannot be stalled. last_of_item_o
// marks the final TRB of a request; busy falls with it, and the next request may
// start in that same cycle.
module transfer_ring_trb_producer import trbp_pkg::*; #(
  parameter int unsigned NUM_RINGS    = NUM_RINGS_DEF,
  parameter int unsigned RING_ENTRIES = RING_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  ring_select_i,
  input  logic [63:0] setup_packet_i,
  input  logic [63:0] buffer_address_i,
  input  logic [16:0] buffer_length_i,
  input  logic [63:0] ring_base_i,
  output logic        result_valid_o,
  output logic [4:0]  out_ring_o,
  output logic [5:0]  trb_slot_o,
  output logic [63:0] trb_pointer_o,
  output logic [31:0] trb_status_o,
  output logic [31:0] trb_control_o,
  output logic        last_of_item_o
);

  cmd_t cmd;
  sts_t sts;

  trbp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  trbp_dpath #(
    .NUM_RINGS    (NUM_RINGS),
    .RING_ENTRIES (RING_ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .ring_select_i    (ring_select_i),
    .setup_packet_i   (setup_packet_i),
    .buffer_address_i (buffer_address_i),
    .buffer_length_i  (buffer_length_i),
    .ring_base_i      (ring_base_i),
    .result_valid_o   (result_valid_o),
    .out_ring_o       (out_ring_o),
    .trb_slot_o       (trb_slot_o),
    .trb_pointer_o    (trb_pointer_o),
    .trb_status_o     (trb_status_o),
    .trb_control_o    (trb_control_o),
    .last_of_item_o   (last_of_item_o)
  );

endmodule

// File: hdl/trbp_checker.sv
// Port-level checks for the transfer ring TRB producer, bound to the top level.
module trbp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic last_of_item_o
);

  // A transfer only comes out of a request in progress
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result without active request");

  // Acceptance is followed by the lookup state, so no TRB in the cycle after acceptance
  a_no_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o) else $error("result right after accept");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  // TRBs of one request come back to back until the last one
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_item_o) |=> result_valid_o)
    else $error("gap inside a request's TRBs");

  a_idle_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_item_o) |-> !busy) else $error("busy after last TRB");

endmodule

bind transfer_ring_trb_producer trbp_checker u_trbp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .last_of_item_o (last_of_item_o)
);
